/* rtl/core/imm_pkg.sv */
`default_nettype none

package imm_pkg;

   localparam int MAX_DIM = 8;
   localparam int IDX_W   = 3;   // row / column / k index
   localparam int DIM_W   = 4;   // dimension registers, 1..MAX_DIM
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 2 * IDX_W;

   // request codes
   localparam logic [1:0] REQ_WRITE_A = 2'd0;
   localparam logic [1:0] REQ_WRITE_B = 2'd1;
   localparam logic [1:0] REQ_COMPUTE = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [1:0] CSR_COLS_B    = 2'd2;

   // operand token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              first;   // k == 0
      logic              last;    // k == inner_dim - 1
      logic [IDX_W-1:0]  k;
      logic [DATA_W-1:0] a;
   } token_type;

   // write of one B element into a cell's column
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  row;
      logic [DATA_W-1:0] data;
   } bwrite_type;

endpackage

`default_nettype wire

/* rtl/core/integer_matrix_multiply.sv */
// Load transactions (write A / write B) are taken one per cycle while no compute
// runs, and give no result. Compute transaction, per row of C: k walk into the
// cell chain, skew down the chain, then the results out.
// Results of a row stream one per cycle while rsp_ready holds; one compute runs at a time.
// Reset (sync, active high): dims return to 8, control clears; A/B stores
// keep no defined value until written.
`default_nettype none

module integer_matrix_multiply (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_type,
   input  wire logic [imm_pkg::IDX_W-1:0]     req_elem_row,
   input  wire logic [imm_pkg::IDX_W-1:0]     req_elem_col,
   input  wire logic signed [imm_pkg::DATA_W-1:0] req_elem_value,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [imm_pkg::IDX_W-1:0]          rsp_out_row,
   output logic [imm_pkg::IDX_W-1:0]          rsp_out_col,
   output logic signed [imm_pkg::DATA_W-1:0]  rsp_dot_value,
   output logic                               rsp_last,
   // configuration write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [imm_pkg::DIM_W-1:0]     csr_wdata
);
   import imm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,    // walk k over row i of A into the chain
      ST_WAIT,    // let the last token reach the last used cell
      ST_DRAIN    // hand out the row, one column per transaction
   } state_type;

   // dimension registers saturate to 1..MAX_DIM on write
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [DIM_W-1:0]   rows_ff, rows_in;
   logic [DIM_W-1:0]   inner_ff, inner_in;
   logic [DIM_W-1:0]   cols_ff, cols_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   // A read pipeline: address in FEED, data and token registered in the next cycle
   logic [DATA_W-1:0]  a_mem [MAX_DIM*MAX_DIM];
   logic [DATA_W-1:0]  a_rdata_ff;
   logic               rd_valid_ff;
   logic               rd_first_ff;
   logic               rd_last_ff;
   logic [IDX_W-1:0]   rd_k_ff;

   logic               req_fire;
   logic               csr_fire;
   logic               out_free;
   logic               k_last;
   logic               j_last;
   logic               i_last;
   logic               clear;
   logic [DIM_W-1:0]   cols_m1;
   logic               done_sel;

   token_type          tok [MAX_DIM];
   bwrite_type         b_wr [MAX_DIM];
   logic [DATA_W-1:0]  results [MAX_DIM];
   logic [MAX_DIM-1:0] done;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign k_last  = ({1'b0, k_ff} == (inner_ff - DIM_W'(1)));
   assign j_last  = ({1'b0, j_ff} == (cols_ff - DIM_W'(1)));
   assign i_last  = ({1'b0, i_ff} == (rows_ff - DIM_W'(1)));
   assign cols_m1 = cols_ff - DIM_W'(1);
   // last used cell finishes last: the whole row is ready then
   assign done_sel = done[cols_m1[IDX_W-1:0]];
   // drop stale done flags as a new row starts
   assign clear    = (state_ff == ST_FEED) && (k_ff == '0);

   // ---------------------------------------------------------------
   // A store: written by load transactions, read once per FEED cycle
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire && (req_type == REQ_WRITE_A)) begin
         a_mem[{req_elem_row, req_elem_col}] <= $unsigned(req_elem_value);
      end
      a_rdata_ff <= a_mem[{i_ff, k_ff}];
   end

   // token entering cell 0
   assign tok[0].valid = rd_valid_ff;
   assign tok[0].first = rd_first_ff;
   assign tok[0].last  = rd_last_ff;
   assign tok[0].k     = rd_k_ff;
   assign tok[0].a     = a_rdata_ff;

   // ---------------------------------------------------------------
   // Cell chain: cell j holds column j of B and accumulates C[i][j].
   // A[i][k] moves one cell per cycle, so each cell runs behind the one before it.
   // ---------------------------------------------------------------
   for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
      assign b_wr[g].en   = req_fire && (req_type == REQ_WRITE_B) &&
                            (req_elem_col == IDX_W'(g));
      assign b_wr[g].row  = req_elem_row;
      assign b_wr[g].data = $unsigned(req_elem_value);

      if (g == MAX_DIM - 1) begin : g_tail
         imm_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .clear   (clear),
            .b_wr    (b_wr[g]),
            .tok_in  (tok[g]),
            .tok_out (),
            .result  (results[g]),
            .done    (done[g])
         );
      end else begin : g_body
         imm_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .clear   (clear),
            .b_wr    (b_wr[g]),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .result  (results[g]),
            .done    (done[g])
         );
      end
   end

   // ---------------------------------------------------------------
   // Sequencer next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      rows_in  = (csr_fire && (csr_index == CSR_ROWS_A))    ? clamp_dim(csr_wdata) : rows_ff;
      inner_in = (csr_fire && (csr_index == CSR_INNER_DIM)) ? clamp_dim(csr_wdata) : inner_ff;
      cols_in  = (csr_fire && (csr_index == CSR_COLS_B))    ? clamp_dim(csr_wdata) : cols_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_type == REQ_COMPUTE)) begin
               i_in     = '0;
               k_in     = '0;
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            if (k_last) begin
               k_in     = '0;
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_WAIT: begin
            if (done_sel) begin
               j_in     = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = i_ff;
               rsp_col_in   = j_ff;
               rsp_value_in = results[j_ff];
               rsp_last_in  = i_last && j_last;
               j_in         = j_ff + IDX_W'(1);
               if (j_last) begin
                  if (i_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in     = i_ff + IDX_W'(1);
                     k_in     = '0;
                     state_in = ST_FEED;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rows_ff      <= DIM_W'(MAX_DIM);
         inner_ff     <= DIM_W'(MAX_DIM);
         cols_ff      <= DIM_W'(MAX_DIM);
         i_ff         <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= (state_ff == ST_FEED);
         rows_ff      <= rows_in;
         inner_ff     <= inner_in;
         cols_ff      <= cols_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
      end
      rd_k_ff      <= k_ff;
      rd_first_ff  <= (k_ff == '0);
      rd_last_ff   <= k_last;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_dot_value = $signed(rsp_value_ff);
   assign rsp_last      = rsp_last_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // every column handed out has finished accumulating
   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> done[j_ff])
      else $error("draining a column whose sum is not finished");

   // tokens only enter the chain from the k walk
   a_tok_src: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == ST_FEED))
      else $error("token entered chain outside feed");

   // handing out the run's final element ends the drain work
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && out_free && i_last && j_last) |=> (state_ff == ST_IDLE))
      else $error("drain still running after the final element");

   // dimensions stay in 1..MAX_DIM
   a_dims: assert property (@(posedge clock) disable iff (reset)
      (rows_ff != '0) && (inner_ff != '0) && (cols_ff != '0) &&
      (rows_ff <= DIM_W'(MAX_DIM)) && (inner_ff <= DIM_W'(MAX_DIM)) &&
      (cols_ff <= DIM_W'(MAX_DIM)))
      else $error("dimension register out of range");

endmodule

`default_nettype wire

/* rtl/core/imm_cell.sv */
`default_nettype none

module imm_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear,
   input  wire imm_pkg::bwrite_type           b_wr,
   input  wire imm_pkg::token_type            tok_in,
   output imm_pkg::token_type                 tok_out,
   output logic [imm_pkg::DATA_W-1:0]         result,
   output logic                               done
);
   import imm_pkg::*;

   // one column of B, indexed by k
   logic [DATA_W-1:0]   b_col_ff [MAX_DIM];
   token_type           tok_ff;
   logic [DATA_W-1:0]   prod_ff;
   logic [DATA_W-1:0]   prod_in;
   logic                p_valid_ff;
   logic                p_first_ff;
   logic                p_last_ff;
   logic [DATA_W-1:0]   acc_ff;
   logic [DATA_W-1:0]   acc_in;
   logic                done_ff;
   logic                done_in;

   // low word of the product is the same for signed and unsigned operands
   assign prod_in = tok_in.a * b_col_ff[tok_in.k];

   always_comb begin
      acc_in  = acc_ff;
      done_in = done_ff;
      if (p_valid_ff) begin
         acc_in = (p_first_ff ? '0 : acc_ff) + prod_ff;
      end
      if (clear) begin
         done_in = 1'b0;
      end else if (p_valid_ff && p_last_ff) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (b_wr.en) begin
         b_col_ff[b_wr.row] <= b_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         p_valid_ff   <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
         p_valid_ff   <= tok_in.valid;
         done_ff      <= done_in;
      end
      tok_ff.first <= tok_in.first;
      tok_ff.last  <= tok_in.last;
      tok_ff.k     <= tok_in.k;
      tok_ff.a     <= tok_in.a;
      prod_ff      <= prod_in;
      p_first_ff   <= tok_in.first;
      p_last_ff    <= tok_in.last;
      acc_ff       <= acc_in;
   end

   assign tok_out = tok_ff;
   assign result  = acc_ff;
   assign done    = done_ff;

endmodule

`default_nettype wire
